// ----- hdl/rv32_subset_instruction_executor_macros.svh -----
// Assertion macros for the rv32 subset executor.
`ifndef RV32_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RV32_SUBSET_INSTRUCTION_EXECUTOR_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define RSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication.
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/rse_pkg.sv -----
// Package: opcodes, ALU function codes and helpers for the rv32 subset executor.
`timescale 1ns / 1ps
`default_nettype none
package rse_pkg;
  localparam int unsigned DmemWords = 4096;
  localparam int unsigned PcBits    = 16;

  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_I      = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;

  localparam logic [31:0] ShiftLimit = 32'd30;

  typedef enum logic [3:0] {
    FN_AND, FN_OR, FN_ADD, FN_SUB, FN_MUL, FN_REM, FN_SLL, FN_LT, FN_GE
  } alu_fn_e;

  // Request from sequencer to shared unit.
  typedef struct packed {
    logic    start;
    alu_fn_e fn;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

  function automatic alu_fn_e base_fn(input logic [2:0] f3);
    alu_fn_e r;
    unique case (f3)
      3'd0:    r = FN_ADD;
      3'd1:    r = FN_SLL;
      3'd6:    r = FN_OR;
      default: r = FN_AND;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/rse_alu.sv -----
// Shared arithmetic unit: registered simple ops, mul and a bit-serial remainder.
`timescale 1ns / 1ps
`default_nettype none
`include "rv32_subset_instruction_executor_macros.svh"
module rse_alu
  import rse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire alu_req_t    req_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output alu_rsp_t         rsp_o,
  output logic [31:0]      res_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d, res_q, res_d;
  logic        neg_q, neg_d, done_q, done_d;
  logic [32:0] trial;
  logic        lt;
  logic [31:0] ma, mb;

  assign lt = (a_i ^ 32'h8000_0000) < (b_i ^ 32'h8000_0000);
  assign ma = a_i[31] ? 32'd0 - a_i : a_i;
  assign mb = b_i[31] ? 32'd0 - b_i : b_i;
  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          done_d = 1'b1;
          unique case (req_i.fn)
            FN_OR:  res_d = a_i | b_i;
            FN_ADD: res_d = a_i + b_i;
            FN_SUB: res_d = a_i - b_i;
            FN_MUL: res_d = a_i * b_i;
            FN_SLL: res_d = (b_i > ShiftLimit) ? 32'd0 : (a_i << b_i[4:0]);
            FN_LT:  res_d = lt ? 32'd0 : 32'd1;
            FN_GE:  res_d = lt ? 32'd1 : 32'd0;
            FN_REM: begin
              if (b_i == 32'd0) begin
                res_d = a_i;
              end else begin
                done_d  = 1'b0;
                state_d = S_DIV;
                rem_d   = 32'd0;
                quo_d   = ma;
                dvs_d   = mb;
                neg_d   = a_i[31];
                cnt_d   = 6'd32;
              end
            end
            default: res_d = a_i & b_i;
          endcase
        end
      end
      S_DIV: begin
        // One restoring step per cycle; quo_q shifts out dividend bits.
        if (!trial[32]) rem_d = trial[31:0];
        else            rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = S_FIX;
      end
      S_FIX: begin
        res_d   = neg_q ? 32'd0 - rem_q : rem_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign res_o      = res_q;

  `RSE_ASSERT(a_div_cnt, clk_i, rst_ni, (state_q == S_DIV) |-> (cnt_q != 6'd0),
    "divider count underflow")
  `RSE_ASSERT_NEXT(a_fix_done, clk_i, rst_ni, state_q == S_FIX, done_q,
    "remainder fixup without done")
  `RSE_ASSERT(a_busy_nostart, clk_i, rst_ni, (state_q != S_IDLE) |-> !req_i.start,
    "start while divider busy")
endmodule
`default_nettype wire

// ----- hdl/rv32_subset_instruction_executor.sv -----
// Top level: sequencer, register file and data memory of the rv32 subset executor.
//
// channel | direction | handshake          | payload
// instr   | in        | instr_valid_i/stall| instr_word_i
// result  | out       | res_valid_o/stall  | next_pc_o .. illegal_opcode_o
//
// Reset clears pc and the register file at once, then sweeps data memory one word a
// cycle while instr_stall_o stays high. A plain word goes from accept through register
// read, unit start, unit result and commit; loads and stores add a memory access, jal
// and unknown opcodes skip the unit wait. rem by a nonzero divisor runs 32 remainder
// steps and one sign fixup in the shared unit.
// One word in flight at a time; the result register holds until taken, and the next
// word is accepted while it waits. Commit stalls while an older result is still held.
`timescale 1ns / 1ps
`default_nettype none
`include "rv32_subset_instruction_executor_macros.svh"
module rv32_subset_instruction_executor
  import rse_pkg::*;
#(
  parameter int unsigned DMEM_WORDS = DmemWords,
  parameter int unsigned PC_BITS    = PcBits
)(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        instr_valid_i,
  output logic             instr_stall_o,
  input  wire logic [31:0] instr_word_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic [15:0]      next_pc_o,
  output logic             reg_write_o,
  output logic [4:0]       reg_index_o,
  output logic signed [31:0] reg_value_o,
  output logic             mem_write_o,
  output logic [11:0]      mem_address_o,
  output logic signed [31:0] store_value_o,
  output logic             illegal_opcode_o
);
  localparam int unsigned AW = $clog2(DMEM_WORDS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;  // register file read
  localparam logic [2:0] S_EXEC = 3'd3;  // start shared unit
  localparam logic [2:0] S_WAIT = 3'd4;  // wait for shared unit
  localparam logic [2:0] S_MEM  = 3'd5;  // memory access
  localparam logic [2:0] S_DONE = 3'd6;  // commit and publish

  logic [2:0]  state_q, state_d;
  logic [AW:0] clr_q;
  logic [31:0] ir_q;
  logic [31:0] a_q, b_q;
  logic [PC_BITS-1:0] pc_q;
  logic [31:0] rf_q [32];
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] rdata_q;
  logic        out_v_q;

  logic [6:0] op;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;
  alu_req_t   req;
  alu_rsp_t   rsp;
  logic [31:0] alu_a, alu_b, alu_res;
  alu_fn_e    fn;
  logic       use_unit;
  logic [AW-1:0] addr;
  logic [PC_BITS-1:0] npc;

  // Commit values.
  logic               commit;
  logic [PC_BITS-1:0] pc_nxt;
  logic               wr_c, mw_c, ill_c;
  logic [4:0]         idx_c;
  logic [31:0]        wb_c, val_c, sval_c;
  logic [11:0]        maddr_c;

  assign op  = ir_q[6:0];
  assign rd  = ir_q[11:7];
  assign f3  = ir_q[14:12];
  assign rs1 = ir_q[19:15];
  assign rs2 = ir_q[24:20];
  assign imm_i = {{20{ir_q[31]}}, ir_q[31:20]};
  assign imm_s = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
  assign imm_b = {{20{ir_q[31]}}, ir_q[31], ir_q[7], ir_q[30:25], ir_q[11:8]};
  assign imm_j = {{12{ir_q[31]}}, ir_q[31], ir_q[19:12], ir_q[20], ir_q[30:21]};
  assign npc   = pc_q + {{(PC_BITS-1){1'b0}}, 1'b1};

  // Function and operands for the shared unit.
  always_comb begin
    fn = FN_AND;
    alu_a = a_q;
    alu_b = b_q;
    use_unit = 1'b1;
    unique case (op)
      OP_R: begin
        if (ir_q[30])      fn = (f3 == 3'd0) ? FN_SUB : FN_AND;
        else if (ir_q[25]) fn = (f3 == 3'd0) ? FN_MUL : (f3 == 3'd6) ? FN_REM : FN_AND;
        else               fn = base_fn(f3);
      end
      OP_I: begin fn = base_fn(f3); alu_b = imm_i; end
      OP_LOAD, OP_JALR: begin fn = FN_ADD; alu_b = imm_i; end
      OP_STORE: begin fn = FN_ADD; alu_b = imm_s; end
      OP_BRANCH: fn = (f3 == 3'd0) ? FN_SUB : (f3 == 3'd4) ? FN_LT :
                      (f3 == 3'd5) ? FN_GE : FN_AND;
      default: use_unit = 1'b0;
    endcase
  end

  assign req.start = (state_q == S_EXEC) && use_unit;
  assign req.fn    = fn;
  assign addr      = alu_res[AW-1:0];

  rse_alu u_alu (
    .clk_i, .rst_ni, .req_i(req), .a_i(alu_a), .b_i(alu_b), .rsp_o(rsp), .res_o(alu_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == DMEM_WORDS[AW:0] - 1'b1) state_d = S_IDLE;
      S_IDLE: if (instr_valid_i && !instr_stall_o) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = use_unit ? S_WAIT : S_DONE;
      S_WAIT: if (rsp.done) state_d = (op == OP_LOAD || op == OP_STORE) ? S_MEM : S_DONE;
      S_MEM:  state_d = S_DONE;
      S_DONE: if (!out_v_q || !res_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign instr_stall_o = (state_q != S_IDLE);
  assign commit = (state_q == S_DONE) && (!out_v_q || !res_stall_i);

  // What the current word reports and writes back.
  always_comb begin
    pc_nxt  = npc;
    wr_c    = 1'b0;
    wb_c    = '0;
    mw_c    = 1'b0;
    maddr_c = '0;
    sval_c  = '0;
    ill_c   = 1'b0;
    unique case (op)
      OP_R, OP_I: begin wr_c = 1'b1; wb_c = alu_res; end
      OP_LOAD: begin
        wr_c    = 1'b1;
        wb_c    = rdata_q;
        maddr_c = 12'(addr);
      end
      OP_STORE: begin
        mw_c    = 1'b1;
        maddr_c = 12'(addr);
        sval_c  = b_q;
      end
      OP_BRANCH: if (alu_res == 32'd0) pc_nxt = pc_q + imm_b[PC_BITS-1:0];
      OP_JAL: begin
        wr_c   = 1'b1;
        wb_c   = 32'(npc);
        pc_nxt = pc_q + imm_j[PC_BITS-1:0];
      end
      OP_JALR: begin
        wr_c   = 1'b1;
        wb_c   = 32'(npc);
        pc_nxt = alu_res[PC_BITS-1:0];
      end
      default: ill_c = 1'b1;
    endcase
    // x0 writes vanish.
    if (rd == 5'd0) wr_c = 1'b0;
    idx_c = wr_c ? rd : 5'd0;
    val_c = wr_c ? wb_c : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLR;
      clr_q            <= '0;
      pc_q             <= '0;
      out_v_q          <= 1'b0;
      next_pc_o        <= '0;
      reg_write_o      <= 1'b0;
      reg_index_o      <= '0;
      reg_value_o      <= '0;
      mem_write_o      <= 1'b0;
      mem_address_o    <= '0;
      store_value_o    <= '0;
      illegal_opcode_o <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      out_v_q <= commit | (out_v_q & res_stall_i);
      if (commit) begin
        pc_q             <= pc_nxt;
        next_pc_o        <= 16'(pc_nxt);
        reg_write_o      <= wr_c;
        reg_index_o      <= idx_c;
        reg_value_o      <= val_c;
        mem_write_o      <= mw_c;
        mem_address_o    <= maddr_c;
        store_value_o    <= sval_c;
        illegal_opcode_o <= ill_c;
        if (wr_c) rf_q[rd] <= wb_c;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && instr_valid_i) ir_q <= instr_word_i;
    if (state_q == S_READ) begin
      a_q <= rf_q[rs1];
      b_q <= rf_q[rs2];
    end
  end

  // Data memory: clear sweep after reset, then stores; registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) dmem[clr_q[AW-1:0]] <= '0;
    else if (state_q == S_MEM && op == OP_STORE) dmem[addr] <= b_q;
    rdata_q <= dmem[addr];
  end

  assign res_valid_o = out_v_q;

  `RSE_ASSERT(a_x0_zero, clk_i, rst_ni, 1'b1 |-> (rf_q[0] == 32'd0), "x0 not zero")
  `RSE_ASSERT(a_wr_idx, clk_i, rst_ni, (out_v_q && reg_write_o) |-> (reg_index_o != 5'd0),
    "register write to x0 reported")
  `RSE_ASSERT(a_clr_stall, clk_i, rst_ni, (state_q == S_CLR) |-> instr_stall_o,
    "accepting during memory clear")
  `RSE_ASSERT(a_mem_excl, clk_i, rst_ni, (out_v_q && mem_write_o) |-> !reg_write_o,
    "store also writes a register")
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the rv32 subset executor: random and directed instruction words, scoreboard check.
`timescale 1ns / 1ps
module testbench;
  import rse_pkg::*;

  // Expected outcome of one instruction word.
  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [11:0] mem_address;
    logic [31:0] store_value;
    logic        illegal_opcode;
  } outcome_t;

  localparam int unsigned CycleLimit = 900000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        instr_valid_i = 1'b0;
  logic        instr_stall_o;
  logic [31:0] instr_word_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic [15:0] next_pc_o;
  logic        reg_write_o;
  logic [4:0]  reg_index_o;
  logic signed [31:0] reg_value_o;
  logic        mem_write_o;
  logic [11:0] mem_address_o;
  logic signed [31:0] store_value_o;
  logic        illegal_opcode_o;

  rv32_subset_instruction_executor i_dut (
    .clk_i, .rst_ni, .instr_valid_i, .instr_stall_o, .instr_word_i,
    .res_valid_o, .res_stall_i, .next_pc_o, .reg_write_o, .reg_index_o,
    .reg_value_o, .mem_write_o, .mem_address_o, .store_value_o, .illegal_opcode_o
  );

  // Shadow architectural state.
  logic [31:0] gpr [32];
  logic [31:0] dmem [DmemWords];
  logic [15:0] pc_q;

  outcome_t    pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // Truncating signed remainder; divide by zero yields the dividend.
  function automatic logic [31:0] srem32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, r;
    if (b == 0) return a;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    r = ma % mb;
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] alu_eval(input alu_fn_e fn, input logic [31:0] a,
                                           input logic [31:0] b);
    case (fn)
      FN_OR:  return a | b;
      FN_ADD: return a + b;
      FN_SUB: return a - b;
      FN_MUL: return a * b;
      FN_REM: return srem32(a, b);
      FN_SLL: return (b > ShiftLimit) ? 32'd0 : a << b[4:0];
      FN_LT:  return ($signed(a) < $signed(b)) ? 32'd0 : 32'd1;
      FN_GE:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      default: return a & b;
    endcase
  endfunction

  function automatic alu_fn_e dec_fn(input logic [2:0] f3);
    case (f3)
      3'd0: return FN_ADD;
      3'd1: return FN_SLL;
      3'd6: return FN_OR;
      default: return FN_AND;
    endcase
  endfunction

  // Executes one word against the shadow state and returns what the block must report.
  function automatic outcome_t execute_word(input logic [31:0] w);
    outcome_t o;
    logic [31:0] a, b, val, imm_i, imm_s, imm_b, imm_j;
    logic [15:0] npc, nxt;
    logic [11:0] addr;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        wr;
    alu_fn_e     fn;
    o = '0;
    rd = w[11:7];
    f3 = w[14:12];
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    npc = pc_q + 16'd1;
    nxt = npc;
    imm_i = sx12(w[31:20]);
    imm_s = sx12({w[31:25], w[11:7]});
    imm_b = sx12({w[31], w[7], w[30:25], w[11:8]});
    imm_j = {{12{w[31]}}, w[31], w[19:12], w[20], w[30:21]};
    wr = 1'b0;
    val = '0;
    addr = '0;
    case (w[6:0])
      OP_R: begin
        if (w[30]) fn = (f3 == 3'd0) ? FN_SUB : FN_AND;
        else if (w[25]) fn = (f3 == 3'd0) ? FN_MUL : (f3 == 3'd6) ? FN_REM : FN_AND;
        else fn = dec_fn(f3);
        wr = 1'b1;
        val = alu_eval(fn, a, b);
      end
      OP_I: begin
        wr = 1'b1;
        val = alu_eval(dec_fn(f3), a, imm_i);
      end
      OP_LOAD: begin
        addr = 12'(a + imm_i);
        wr = 1'b1;
        val = dmem[addr];
      end
      OP_STORE: begin
        addr = 12'(a + imm_s);
        o.mem_write = 1'b1;
        o.store_value = b;
        dmem[addr] = b;
      end
      OP_BRANCH: begin
        fn = (f3 == 3'd0) ? FN_SUB : (f3 == 3'd4) ? FN_LT : (f3 == 3'd5) ? FN_GE : FN_AND;
        if (alu_eval(fn, a, b) == 0) nxt = pc_q + imm_b[15:0];
      end
      OP_JAL: begin
        wr = 1'b1;
        val = {16'd0, npc};
        nxt = pc_q + imm_j[15:0];
      end
      OP_JALR: begin
        wr = 1'b1;
        val = {16'd0, npc};
        nxt = 16'(a + imm_i);
      end
      default: o.illegal_opcode = 1'b1;
    endcase
    // x0 is hardwired; writes to it vanish.
    if (wr && rd != 0) begin
      gpr[rd] = val;
      o.reg_write = 1'b1;
      o.reg_index = rd;
      o.reg_value = val;
    end
    gpr[0] = '0;
    pc_q = nxt;
    o.next_pc = nxt;
    o.mem_address = addr;
    return o;
  endfunction

  // Sends one word; the prediction is made at acceptance. Valid stays up after the
  // accept so back-to-back calls never touch it twice in one step.
  task automatic send_word(input logic [31:0] w);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      instr_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_valid_i <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (instr_stall_o);
    pending_q = {pending_q, execute_word(w)};
  endtask

  // Result stalls in bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        res_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        res_stall_i <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      got = {next_pc_o, reg_write_o, reg_index_o, reg_value_o, mem_write_o,
             mem_address_o, store_value_o, illegal_opcode_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pc %h wr %b rd %0d val %h mw %b addr %h sv %h ill %b",
                     want.next_pc, want.reg_write, want.reg_index, want.reg_value,
                     want.mem_write, want.mem_address, want.store_value,
                     want.illegal_opcode,
                     " | got pc %h wr %b rd %0d val %h mw %b addr %h sv %h ill %b",
                     got.next_pc, got.reg_write, got.reg_index,
                     got.reg_value, got.mem_write, got.mem_address, got.store_value,
                     got.illegal_opcode);
        end
      end
    end
  end

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  // Register-operand extremes, ALU corners and special cases.
  task automatic test_directed();
    send_word(enc_i(12'h7ff, 5'd0, 3'd0, 5'd1, OP_I));          // x1 = 2047
    send_word(enc_i(12'h800, 5'd0, 3'd0, 5'd2, OP_I));          // x2 = -2048
    send_word(enc_i(12'd31, 5'd1, 3'd1, 5'd3, OP_I));           // shift above limit
    send_word(enc_i(12'd20, 5'd1, 3'd1, 5'd3, OP_I));           // x3 = 2047 << 20
    send_word(enc_i(12'd5, 5'd1, 3'd0, 5'd0, OP_I));            // write to x0 dropped
    send_word(enc_i(12'hfff, 5'd0, 3'd0, 5'd4, OP_I));          // x4 = -1
    send_word(enc_i(12'd1, 5'd0, 3'd0, 5'd5, OP_I));
    send_word(enc_i(12'd31, 5'd5, 3'd1, 5'd5, OP_I));           // slli by 31 -> 0
    send_word(enc_r(7'h00, 5'd0, 5'd4, 3'd6, 5'd6, OP_R));      // x6 = -1 | 0
    send_word(enc_i(12'h001, 5'd0, 3'd0, 5'd7, OP_I));
    send_word(enc_i(12'h01f, 5'd7, 3'd0, 5'd7, OP_I));          // x7 = 32
    send_word(enc_r(7'h00, 5'd7, 5'd7, 3'd1, 5'd8, OP_R));      // x7 << 32 -> 0
    send_word(enc_r(7'h01, 5'd0, 5'd2, 3'd6, 5'd9, OP_R));      // rem by zero
    send_word(enc_r(7'h01, 5'd1, 5'd2, 3'd6, 5'd9, OP_R));      // negative dividend
    send_word(enc_r(7'h01, 5'd4, 5'd3, 3'd0, 5'd10, OP_R));     // mul
    send_word(enc_r(7'h20, 5'd1, 5'd2, 3'd0, 5'd11, OP_R));     // sub
    send_word(enc_r(7'h20, 5'd1, 5'd2, 3'd3, 5'd11, OP_R));     // sub flavor, other f3
    send_word({7'h7f, 5'd4, 5'd0, 3'd2, 5'h1f, OP_STORE});     // store to wrapped address
    send_word(enc_i(12'hfff, 5'd0, 3'd2, 5'd12, OP_LOAD));
    send_word({1'b1, 6'h3f, 5'd2, 5'd1, 3'd4, 4'hf, 1'b1, OP_BRANCH}); // blt
    send_word({1'b0, 6'h01, 5'd1, 5'd2, 3'd2, 4'h0, 1'b0, OP_BRANCH}); // and-zero case
    send_word({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd1, OP_JAL});
    send_word(enc_i(12'h800, 5'd4, 3'd0, 5'd13, OP_JALR));
    send_word(32'hffff_ffff);                                   // illegal opcode
    send_word(32'h0000_0000);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    logic [6:0] ops [7] = '{OP_R, OP_I, OP_LOAD, OP_STORE, OP_BRANCH, OP_JAL, OP_JALR};
    w = $urandom();
    // Mostly legal opcodes; small registers so values get reused.
    if ($urandom_range(0, 19) != 0) w[6:0] = ops[$urandom_range(0, 6)];
    if ($urandom_range(0, 1)) begin
      w[19:15] = 5'($urandom_range(0, 7));
      w[24:20] = 5'($urandom_range(0, 7));
      w[11:7] = 5'($urandom_range(0, 7));
    end
    if (w[6:0] == OP_R && $urandom_range(0, 1))
      w[31:25] = {1'b0, $urandom_range(0, 1) ? 6'h00 : 6'h01};
    return w;
  endfunction

  task automatic test_random(input int unsigned count);
    repeat (count) send_word(rand_word());
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DmemWords; i++) dmem[i] = '0;
    pc_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    idle_en = 1'b0;
    test_random(125);
    instr_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
